### src/timed_lowest_free_server_allocator_assert.svh
`ifndef TIMED_LOWEST_FREE_SERVER_ALLOCATOR_ASSERT_SVH
`define TIMED_LOWEST_FREE_SERVER_ALLOCATOR_ASSERT_SVH

// property checked only while out of reset
`define TLFSA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define TLFSA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tlfsa_pkg.sv
package tlfsa_pkg;

  localparam int MaxServers = 128;

  localparam int ArrW   = 20;
  localparam int NeedW  = 8;
  localparam int HoldW  = 10;
  localparam int CfgW   = 8;
  localparam int SumW   = 14;
  localparam int BusyW  = 21;
  localparam int CntW   = $clog2(MaxServers + 1);

  localparam logic [CfgW-1:0] ServerCountRst = CfgW'(128);

  typedef struct packed {
    logic [ArrW-1:0]  arrival_time;
    logic [NeedW-1:0] needed_count;
    logic [HoldW-1:0] hold_time;
  } req_t;

  typedef struct packed {
    logic            granted;
    logic [SumW-1:0] id_sum;
  } res_t;

  // token walking down the cell chain
  typedef struct packed {
    logic             valid;
    logic             alloc;     // 0: counting pass, 1: allocation pass
    logic [NeedW-1:0] need_left;
    logic [CntW-1:0]  act_left;  // active servers not yet visited
    logic [CntW-1:0]  pos;       // zero-based number of the next cell
    logic [SumW-1:0]  sum;
  } tok_t;

endpackage

### src/tlfsa_cell.sv
module tlfsa_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tlfsa_pkg::tok_t            tok_i,
  input  logic [tlfsa_pkg::ArrW-1:0]  now_i,
  input  logic [tlfsa_pkg::BusyW-1:0] busy_val_i,
  output tlfsa_pkg::tok_t            tok_o
);

  logic [tlfsa_pkg::BusyW-1:0] busy_q, busy_d;
  tlfsa_pkg::tok_t             tok_q, tok_d;
  logic                        free, live, hit;
  logic [tlfsa_pkg::CntW-1:0]  pos_nx;

  always_comb begin
    free   = busy_q <= tlfsa_pkg::BusyW'(now_i);
    live   = tok_i.act_left != '0;
    hit    = tok_i.valid && free && live && (tok_i.need_left != '0);
    pos_nx = tok_i.pos + 1'b1;

    tok_d     = tok_i;
    tok_d.pos = pos_nx;
    if (live) begin
      tok_d.act_left = tok_i.act_left - 1'b1;
    end
    if (hit) begin
      tok_d.need_left = tok_i.need_left - 1'b1;
    end
    if (hit && tok_i.alloc) begin
      // server number is one-based
      tok_d.sum = tok_i.sum + tlfsa_pkg::SumW'(pos_nx);
    end

    busy_d = (hit && tok_i.alloc) ? busy_val_i : busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= '0;
      tok_q.valid <= 1'b0;
    end else begin
      busy_q <= busy_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### src/timed_lowest_free_server_allocator.sv
// channel   | direction | handshake             | beat
// ----------+-----------+-----------------------+-----------------------------
// request   | in        | start, busy           | req_i (arrival, need, hold)
// result    | out       | done_o strobe         | res_o (granted, id_sum)
// config    | in        | cfg_valid_i/ready_o   | cfg_data_i (server count)
//
// a request walks the cell chain once or twice: one pass counts free servers,
// and only if enough are free a second pass takes the lowest free ones and sums
// their numbers; done_o rises after the counting pass for a rejected request
// and after the allocation pass for a granted one; busy is low again in the
// done_o cycle, so a new request can start then
// server count is sampled at accept; reset clears every busy-until time at once
// results cannot stall
module timed_lowest_free_server_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  tlfsa_pkg::req_t           req_i,
  output logic                      done_o,
  output tlfsa_pkg::res_t           res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [tlfsa_pkg::CfgW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StCount = 3'b010,
    StAlloc = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [tlfsa_pkg::CfgW-1:0]   srv_cnt_q;
  logic [tlfsa_pkg::ArrW-1:0]   now_q, now_d;
  logic [tlfsa_pkg::NeedW-1:0]  need_q, need_d;
  logic [tlfsa_pkg::BusyW-1:0]  busy_val_q, busy_val_d;
  logic [tlfsa_pkg::CntW-1:0]   act_n;
  logic [tlfsa_pkg::CntW-1:0]   act_q, act_d;
  tlfsa_pkg::tok_t              inj_q, inj_d;
  tlfsa_pkg::res_t              res_q, res_d;
  logic                         done_q, done_d;
  logic                         accept;
  tlfsa_pkg::tok_t              chain [tlfsa_pkg::MaxServers+1];
  tlfsa_pkg::tok_t              tail;

  assign busy        = state_q != StIdle;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign chain[0]    = inj_q;
  assign tail        = chain[tlfsa_pkg::MaxServers];

  for (genvar g = 0; g < tlfsa_pkg::MaxServers; g++) begin : g_cell
    tlfsa_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (chain[g]),
      .now_i     (now_q),
      .busy_val_i(busy_val_q),
      .tok_o     (chain[g+1])
    );
  end

  always_comb begin
    if (32'(srv_cnt_q) > 32'(tlfsa_pkg::MaxServers)) begin
      act_n = tlfsa_pkg::CntW'(tlfsa_pkg::MaxServers);
    end else begin
      act_n = tlfsa_pkg::CntW'(srv_cnt_q);
    end
  end

  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    need_d     = need_q;
    busy_val_d = busy_val_q;
    act_d      = act_q;
    inj_d      = inj_q;
    inj_d.valid = 1'b0;
    res_d      = res_q;
    done_d     = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          now_d      = req_i.arrival_time;
          need_d     = req_i.needed_count;
          act_d      = act_n;
          busy_val_d = tlfsa_pkg::BusyW'(req_i.arrival_time)
                     + tlfsa_pkg::BusyW'(req_i.hold_time);
          inj_d.valid     = 1'b1;
          inj_d.alloc     = 1'b0;
          inj_d.need_left = req_i.needed_count;
          inj_d.act_left  = act_n;
          inj_d.pos       = '0;
          inj_d.sum       = '0;
          state_d         = StCount;
        end
      end
      StCount: begin
        if (tail.valid) begin
          if (tail.need_left == '0) begin
            // enough free servers: send the allocation pass
            inj_d.valid     = 1'b1;
            inj_d.alloc     = 1'b1;
            inj_d.need_left = need_q;
            inj_d.act_left  = act_q;
            inj_d.pos       = '0;
            inj_d.sum       = '0;
            state_d         = StAlloc;
          end else begin
            res_d.granted = 1'b0;
            res_d.id_sum  = '0;
            done_d        = 1'b1;
            state_d       = StIdle;
          end
        end
      end
      StAlloc: begin
        if (tail.valid) begin
          res_d.granted = 1'b1;
          res_d.id_sum  = tail.sum;
          done_d        = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      srv_cnt_q   <= tlfsa_pkg::ServerCountRst;
      inj_q.valid <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= inj_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        srv_cnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    need_q     <= need_d;
    busy_val_q <= busy_val_d;
    act_q      <= act_d;
    res_q      <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### src/tlfsa_checker.sv
`include "timed_lowest_free_server_allocator_assert.svh"

module tlfsa_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input tlfsa_pkg::res_t res_o
);

  `TLFSA_ASSERT(a_busy_after_start, clk_i, rst_ni, start && !busy |=> busy, "busy not set after accept")
  `TLFSA_ASSERT(a_done_not_busy, clk_i, rst_ni, done_o |-> !busy, "result shown while busy")
  `TLFSA_ASSERT(a_no_done_after_start, clk_i, rst_ni, start && !busy |=> !done_o, "result right after accept")
  `TLFSA_ASSERT_ALWAYS(a_reject_zero_sum, clk_i, done_o && !res_o.granted |-> res_o.id_sum == '0, "rejection with nonzero sum")

endmodule

bind timed_lowest_free_server_allocator tlfsa_checker u_tlfsa_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .res_o (res_o)
);

### tb/sv/server_alloc_checker.sv
`timescale 1ns / 100ps

module server_alloc_checker
  import tlfsa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  req_t            req_i,
  input  logic            done_o,
  input  res_t            res_o,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_o,
  input  logic [CfgW-1:0] cfg_data_i,
  output int unsigned     fail_count,
  output int unsigned     pending
);

  localparam int unsigned PrintCap = 100;

  logic [BusyW-1:0] busy_until_q [MaxServers];
  logic [CfgW-1:0]  server_count_q;
  res_t             grant_q [$];
  res_t             oldest;

  initial fail_count = 0;

  task automatic report(input string msg);
    if (fail_count < PrintCap) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  // counts free servers first; takes the lowest free ones only if enough are free
  function automatic res_t allot_servers(input req_t r);
    int unsigned active;
    int unsigned free_cnt;
    int unsigned taken;
    int unsigned id_total;
    res_t        grant;
    active   = (server_count_q > MaxServers) ? MaxServers : server_count_q;
    free_cnt = 0;
    taken    = 0;
    id_total = 0;
    for (int i = 0; i < active; i++) begin
      if (busy_until_q[i] <= BusyW'(r.arrival_time)) free_cnt++;
    end
    if (free_cnt < r.needed_count) begin
      grant.granted = 1'b0;
      grant.id_sum  = '0;
      return grant;
    end
    for (int i = 0; i < active && taken < r.needed_count; i++) begin
      if (busy_until_q[i] <= BusyW'(r.arrival_time)) begin
        busy_until_q[i] = BusyW'(r.arrival_time) + BusyW'(r.hold_time);
        id_total += i + 1;
        taken++;
      end
    end
    grant.granted = 1'b1;
    grant.id_sum  = SumW'(id_total);
    return grant;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_count_q = ServerCountRst;
      for (int i = 0; i < MaxServers; i++) busy_until_q[i] = '0;
      grant_q.delete();
      pending <= 0;
    end else begin
      if (done_o === 1'b1) begin
        if (grant_q.size() == 0) begin
          report($sformatf("result with nothing outstanding: granted %0b id_sum %0d",
                           res_o.granted, res_o.id_sum));
        end else begin
          oldest = grant_q.pop_front();
          if (res_o.granted !== oldest.granted)
            report($sformatf("granted %0b, expected %0b", res_o.granted, oldest.granted));
          if (res_o.id_sum !== oldest.id_sum)
            report($sformatf("id_sum %0d, expected %0d", res_o.id_sum, oldest.id_sum));
        end
      end
      if (start && !busy) grant_q.push_back(allot_servers(req_i));
      if (cfg_valid_i && cfg_ready_o) server_count_q = cfg_data_i;
      pending <= grant_q.size();
    end
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tlfsa_pkg::*;

  localparam int unsigned IdleLimit    = 4000;
  localparam int unsigned PhaseItems   = 120;
  localparam int unsigned ArrMax       = (1 << ArrW) - 1;
  localparam int unsigned PhaseCounts [12] =
    '{128, 1, 7, 32, 0, 200, 64, 3, 255, 16, 100, 128};

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  req_t            req;
  logic            done_o;
  res_t            res;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CfgW-1:0] cfg_data;
  int unsigned     fail_count;
  int unsigned     pending;
  int unsigned     idle_cycles;
  int unsigned     req_time;

  always #10 clk_i = ~clk_i;

  timed_lowest_free_server_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done_o),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  server_alloc_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done_o),
    .res_o       (res),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // request beat: start stays high through back-to-back beats
  task automatic issue(input int unsigned t, input int unsigned need,
                       input int unsigned hold, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= '{arrival_time: ArrW'(t), needed_count: NeedW'(need), hold_time: HoldW'(hold)};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain_grants();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_server_count(input int unsigned cnt);
    cfg_valid <= 1'b1;
    cfg_data  <= CfgW'(cnt);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request(input int unsigned active, input bit no_idle);
    int unsigned pick;
    int unsigned need;
    int unsigned hold;
    pick = $urandom_range(0, 99);
    if (pick < 4) req_time = (req_time > 500) ? req_time - $urandom_range(0, 500) : 0;
    else if (pick < 9) req_time += $urandom_range(0, 2000);
    else req_time += $urandom_range(0, 25);
    if (req_time > ArrMax) req_time = ArrMax;
    pick = $urandom_range(0, 99);
    if (pick < 3) need = 0;
    else if (pick < 6) need = $urandom_range(0, 255);
    else if (pick < 20) need = $urandom_range(1, active + 2);
    else need = $urandom_range(1, active / 4 + 1);
    hold = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 60) : $urandom_range(0, 1023);
    issue(req_time, need, hold, no_idle ? 0 : $urandom_range(0, 14));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    bit no_idle;
    int unsigned active;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req         = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    idle_cycles = 0;
    req_time    = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_server_count(128);
    issue(0, 1, 1, 0);
    issue(1, 1, 5, $urandom_range(0, 14));       // release at t before request at t
    issue(1, 3, 1023, $urandom_range(0, 14));
    issue(2, 0, 7, $urandom_range(0, 14));       // nothing needed
    issue(2, 128, 1, $urandom_range(0, 14));     // too few free
    issue(2, 124, 1, $urandom_range(0, 14));
    issue(3, 1, 0, 0);                           // zero hold frees at once
    issue(3, 1, 1, 0);
    issue(1050, 128, 1023, $urandom_range(0, 14));
    issue(1050, 1, 1, $urandom_range(0, 14));
    issue(2073, 255, 9, $urandom_range(0, 14));
    issue(2073, 128, 1, 0);
    issue(500, 1, 1, 0);                         // time going backwards
    drain_grants();
    set_server_count(0);
    issue(2074, 1, 1, 0);
    issue(2074, 0, 1, $urandom_range(0, 14));
    drain_grants();
    set_server_count(255);                       // saturates at the table size
    issue(2074, 128, 2, 0);
    issue(2076, 129, 2, 0);
    drain_grants();
    set_server_count(4);
    issue(2076, 2, 500, 0);
    issue(2076, 3, 1, $urandom_range(0, 14));
    drain_grants();
    set_server_count(8);                         // upper servers keep old busy times
    issue(2077, 6, 1, 0);
    req_time = 2077;

    foreach (PhaseCounts[p]) begin
      drain_grants();
      set_server_count(PhaseCounts[p]);
      active   = (PhaseCounts[p] > MaxServers) ? MaxServers : PhaseCounts[p];
      no_idle  = ($urandom_range(0, 2) == 0);
      req_time += $urandom_range(0, 60000);
      repeat (PhaseItems) begin
        random_request(active, no_idle);
        if ($urandom_range(0, 99) == 0) drain_grants();
      end
    end

    // times at the top of the range last, they leave the table busy for good
    drain_grants();
    set_server_count(128);
    issue(ArrMax, 128, 1023, 0);
    issue(ArrMax, 1, 0, $urandom_range(0, 14));

    drain_grants();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
